// File: rtl/core/dsf_pkg.sv
// Shared types, register codes, constants and the belief step table of the depth stack fusion unit.
package dsf_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int BELIEF_W = 8;
    localparam int FRAMES_W = 6;
    localparam int LIMIT_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STACK_FRAMES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_LIMIT = 1'd1;

    // Register reset values
    localparam logic [FRAMES_W-1:0] STACK_FRAMES_RESET   = 6'd8;
    localparam logic [LIMIT_W-1:0]  VARIANCE_LIMIT_RESET = 16'd1000;

    // Full belief and the least number of valid samples for a pixel to pass
    localparam logic [BELIEF_W-1:0] BELIEF_FULL = 8'd255;
    localparam int MIN_VALID = 3;

    // Belief step per missing sample, floor(255 / N), indexed by the stack length N.
    // Entry zero is never used, since a stack length of zero is treated as one.
    localparam logic [BELIEF_W-1:0] STEP_TABLE [64] = '{
        8'd255, 8'd255, 8'd127, 8'd85,  8'd63,  8'd51,  8'd42,  8'd36,
        8'd31,  8'd28,  8'd25,  8'd23,  8'd21,  8'd19,  8'd18,  8'd17,
        8'd15,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,
        8'd10,  8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,
        8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd6,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4
    };

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic mul;
        logic load_out;
    } dsf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic div_last;
    } dsf_status_t;

endpackage

// File: rtl/core/dsf_ctrl.sv
// Controller state machine of the depth stack fusion unit.
module dsf_ctrl
    import dsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        m_ready,
    output logic        m_valid,
    input  dsf_status_t status,
    output dsf_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // State and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.accumulate = 1'b1;
                if (status.last) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // The result register must be free or emptying this cycle.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result word stays until the consumer takes it.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/dsf_datapath.sv
// Datapath of the depth stack fusion unit: accumulators, divider, gate and result register.
module dsf_datapath
    import dsf_pkg::*;
#(
    parameter int MAX_FRAMES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dsf_cmd_t            cmd,
    output dsf_status_t         status,
    input  logic [FRAMES_W-1:0] stack_frames,
    input  logic [LIMIT_W-1:0]  variance_limit,
    input  logic [SAMPLE_W-1:0] s_depth_sample,
    output logic [SAMPLE_W-1:0] m_fused_depth,
    output logic [BELIEF_W-1:0] m_belief,
    output logic                m_accepted
);

    // Widths that follow from the stack depth
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int NW  = (CW > FRAMES_W) ? CW : FRAMES_W;
    localparam int SW  = SAMPLE_W + CW;
    localparam int QW  = 2 * SAMPLE_W + CW;
    localparam int DW  = SAMPLE_W + SW + 1;
    localparam int LW  = LIMIT_W + CW;
    localparam int BW  = BELIEF_W + CW;
    localparam int DCW = $clog2(SW);

    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       zc_reg;
    logic [SW-1:0]       sum_reg;
    logic [QW-1:0]       sq_reg;
    logic [SW-1:0]       quo_reg;
    logic [CW-1:0]       rem_reg;
    logic [DCW-1:0]      div_cnt_reg;
    logic [DW-1:0]       prod_reg;
    logic [LW-1:0]       lim_reg;
    logic [BW-1:0]       drop_reg;
    logic [SAMPLE_W-1:0] fused_reg;
    logic [BELIEF_W-1:0] belief_reg;
    logic                accepted_reg;

    logic [NW-1:0]       frames_ext;
    logic [NW-1:0]       n_eff;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       k_val;
    logic                k_ok;
    logic [SW-1:0]       sum_next;
    logic [QW-1:0]       sq_next;
    logic [CW:0]         trial;
    logic                trial_ge;
    logic [CW:0]         trial_diff;
    logic [SAMPLE_W-1:0] mean;
    logic [SW:0]         sum_plus_rem;
    logic [DW-1:0]       prod_next;
    logic [CW-1:0]       k_minus2;
    logic [LW-1:0]       lim_next;
    logic [BW-1:0]       drop_next;
    logic [DW-1:0]       deviation;
    logic                pass;
    logic [BELIEF_W-1:0] belief_calc;

    // Stack length in use: zero acts as one, anything above the depth as the depth
    assign frames_ext = NW'(stack_frames);
    always_comb begin
        if (stack_frames == '0) begin
            n_eff = NW'(1);
        end else if (frames_ext > NW'(MAX_FRAMES)) begin
            n_eff = NW'(MAX_FRAMES);
        end else begin
            n_eff = frames_ext;
        end
    end

    // Valid sample count and the minimum count check
    assign idx_inc = idx_reg + CW'(1);
    assign k_val   = idx_reg - zc_reg;
    assign k_ok    = (k_val >= CW'(MIN_VALID));

    // Accumulator updates; a zero sample adds nothing to either sum.
    assign sum_next = sum_reg + SW'(sample_reg);
    assign sq_next  = sq_reg + QW'(sample_reg) * QW'(sample_reg);

    // Sample word capture and the end of pixel flag
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sample_reg <= s_depth_sample;
            last_reg   <= (NW'(idx_inc) >= n_eff);
        end
    end

    // Pixel accumulators; cleared once the result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            zc_reg  <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (cmd.load_out) begin
            idx_reg <= '0;
            zc_reg  <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (cmd.accumulate) begin
            idx_reg <= idx_inc;
            zc_reg  <= zc_reg + CW'(sample_reg == '0);
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
    end

    // Restoring divider step: one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[SW-1]};
    assign trial_ge   = (trial >= {1'b0, k_val});
    assign trial_diff = trial - {1'b0, k_val};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg     <= sum_next;
            rem_reg     <= '0;
            div_cnt_reg <= DCW'(SW - 1);
        end else if (cmd.div_step) begin
            quo_reg     <= {quo_reg[SW-2:0], trial_ge};
            rem_reg     <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    assign status.last     = last_reg;
    assign status.div_last = (div_cnt_reg == '0);

    // The mean never exceeds the largest sample, so it fits a sample word.
    assign mean = quo_reg[SAMPLE_W-1:0];

    // Deviation sum Q - 2mS + k*m*m equals Q - m*(S + r), with r the remainder.
    assign sum_plus_rem = {1'b0, sum_reg} + (SW + 1)'(rem_reg);
    assign prod_next    = DW'(mean) * DW'(sum_plus_rem);
    assign k_minus2     = k_val - CW'(2);
    assign lim_next     = LW'(variance_limit) * LW'(k_minus2);
    assign drop_next    = BW'(STEP_TABLE[n_eff[FRAMES_W-1:0]]) * BW'(zc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= prod_next;
            lim_reg  <= lim_next;
            drop_reg <= drop_next;
        end
    end

    // Variance gate and belief
    assign deviation = DW'(sq_reg) - prod_reg;
    assign pass      = k_ok && (deviation < DW'(lim_reg));

    always_comb begin
        if (drop_reg <= BW'(BELIEF_FULL)) begin
            belief_calc = BELIEF_FULL - drop_reg[BELIEF_W-1:0];
        end else begin
            belief_calc = '0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            fused_reg    <= pass ? mean : '0;
            belief_reg   <= pass ? belief_calc : '0;
            accepted_reg <= pass;
        end
    end

    assign m_fused_depth = fused_reg;
    assign m_belief      = belief_reg;
    assign m_accepted    = accepted_reg;

endmodule

// File: rtl/core/depth_stack_fusion_unit.sv
// Top level of the depth stack fusion unit: configuration registers, controller and datapath.
// Each depth sample is captured into the sample register in IDLE and accumulated in ACC.
// After a pixel's last sample the bit-serial divider forms the mean, the products are registered
// in MUL and the result word is loaded in FIN. A held word stalls the next pixel's finish.
// Reset is synchronous and active low: accumulators clear, registers return to 8 frames and 1000.
module depth_stack_fusion_unit
    import dsf_pkg::*;
#(
    parameter int MAX_FRAMES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_depth_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SAMPLE_W-1:0]  m_fused_depth,
    output logic [BELIEF_W-1:0]  m_belief,
    output logic                 m_accepted,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    logic [FRAMES_W-1:0] stack_frames_reg;
    logic [LIMIT_W-1:0]  variance_limit_reg;
    dsf_cmd_t            ctrl_cmd;
    dsf_status_t         dp_status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_frames_reg   <= STACK_FRAMES_RESET;
            variance_limit_reg <= VARIANCE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STACK_FRAMES: begin
                    stack_frames_reg <= cfg_wr_data[FRAMES_W-1:0];
                end
                REG_VARIANCE_LIMIT: begin
                    variance_limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Controller
    dsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // Datapath
    dsf_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctrl_cmd),
        .status         (dp_status),
        .stack_frames   (stack_frames_reg),
        .variance_limit (variance_limit_reg),
        .s_depth_sample (s_depth_sample),
        .m_fused_depth  (m_fused_depth),
        .m_belief       (m_belief),
        .m_accepted     (m_accepted)
    );

    // A captured sample word is always accumulated in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && ctrl_cmd.accumulate))
        else $error("sample word not accumulated after capture");

    // A rejected pixel carries zero depth and zero belief.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_fused_depth == '0 && m_belief == '0))
        else $error("rejected pixel carries nonzero fields");

    // An accepted pixel has at least three nonzero samples, so its mean is nonzero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_fused_depth != '0))
        else $error("accepted pixel with zero mean");

    // Loading the result register always presents a result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.load_out |=> m_valid)
        else $error("result loaded but not presented");

    // The divider never runs while samples are taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.div_step |-> (!s_ready && !ctrl_cmd.load_out))
        else $error("divider active outside the finishing sequence");

endmodule
